/* design/cpfa_pkg.sv */
`default_nettype none

package cpfa_pkg;

   // Frame map geometry
   localparam int NUM_FRAMES  = 1024;
   localparam int FRAME_BYTES = 4096;
   localparam int IDX_W       = $clog2(NUM_FRAMES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int PAGE_SHIFT  = $clog2(FRAME_BYTES);

   // Field widths
   localparam int OP_W       = 2;
   localparam int NPAGES_W   = 11;
   localparam int ADDR_W     = 32;
   localparam int OWNER_W    = 15;
   localparam int PIDX_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int PHYS_W     = 22;
   localparam int USED_W     = 23;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes and reset values
   localparam logic [1:0] REG_RESERVED = 2'd0;
   localparam logic [1:0] REG_PRESENT  = 2'd1;
   localparam logic [1:0] REG_KBASE    = 2'd2;

   localparam logic [CNT_W-1:0]  RESERVED_RST = '0;
   localparam logic [CNT_W-1:0]  PRESENT_RST  = CNT_W'(NUM_FRAMES);
   localparam logic [ADDR_W-1:0] KBASE_RST    = 32'h8000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC      = 2'd0,
      OP_FREE_ADDR  = 2'd1,
      OP_FREE_INDEX = 2'd2,
      OP_USAGE      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_RUN    = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   // One record of the frame map
   typedef struct packed {
      logic                used;
      logic                first;
      logic [NPAGES_W-1:0] len;
      logic [OWNER_W-1:0]  owner;
      logic [ADDR_W-1:0]   vaddr;
   } frame_rec_type;

   typedef struct packed {
      logic [CNT_W-1:0]  reserved;
      logic [CNT_W-1:0]  present;
      logic [ADDR_W-1:0] kernel_base;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      frame_rec_type     data;
   } ram_wr_type;

   // Operands of the shared compare unit
   typedef struct packed {
      frame_rec_type       rec;
      logic [ADDR_W-1:0]   vaddr;
      logic [OWNER_W-1:0]  owner;
      logic [NPAGES_W-1:0] npages;
      logic [CNT_W-1:0]    run_cnt;
      logic [CNT_W-1:0]    base;
      logic [CNT_W-1:0]    top;
   } scan_ctx_type;

   typedef struct packed {
      logic match;
      logic run_done;
      logic fits;
   } scan_res_type;

endpackage

`default_nettype wire

/* design/cpfa_frame_ram.sv */
`default_nettype none

module cpfa_frame_ram
   import cpfa_pkg::*;
(
   input  logic             clock,
   input  ram_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output frame_rec_type    rd_data
);

   frame_rec_type mem [NUM_FRAMES];
   frame_rec_type rd_data_ff;

   // Write one record, read one record with registered data
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/cpfa_scan_unit.sv */
`default_nettype none

module cpfa_scan_unit
   import cpfa_pkg::*;
(
   input  scan_ctx_type ctx,
   output scan_res_type res
);

   logic [CNT_W:0] cnt_next;
   logic [CNT_W:0] run_end;

   // Advance the free run and find where a run from base would end
   assign cnt_next = {1'b0, ctx.run_cnt} + {{CNT_W{1'b0}}, 1'b1};
   assign run_end  = {1'b0, ctx.base} + {{(CNT_W + 1 - NPAGES_W){1'b0}}, ctx.npages};

   always_comb begin
      res.match    = ctx.rec.used && (ctx.rec.vaddr == ctx.vaddr) &&
                     (ctx.rec.owner == ctx.owner);
      res.run_done = cnt_next == {{(CNT_W + 1 - NPAGES_W){1'b0}}, ctx.npages};
      res.fits     = run_end <= {1'b0, ctx.top};
   end

endmodule

`default_nettype wire

/* design/cpfa_ctrl.sv */
`default_nettype none

module cpfa_ctrl
   import cpfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [NPAGES_W-1:0] req_npages,
   input  logic [ADDR_W-1:0]   req_vaddr,
   input  logic [OWNER_W-1:0]  req_owner,
   input  logic [PIDX_W-1:0]   req_page_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PHYS_W-1:0]   rsp_phys_addr,
   output logic [ADDR_W-1:0]   rsp_virt_addr,
   output logic [USED_W-1:0]   rsp_used_bytes,
   output ram_wr_type          ram_wr,
   output logic [IDX_W-1:0]    ram_rd_addr,
   input  frame_rec_type       ram_rd_data
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_ASCAN  = 9'b000000100,
      ST_AMARK  = 9'b000001000,
      ST_FSCAN  = 9'b000010000,
      ST_FCLEAR = 9'b000100000,
      ST_XREAD  = 9'b001000000,
      ST_XCHECK = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [NPAGES_W-1:0] npages_ff, npages_in;
   logic [ADDR_W-1:0]   vaddr_ff, vaddr_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [CNT_W-1:0]    issue_ptr_ff, issue_ptr_in;
   logic [CNT_W-1:0]    eval_ptr_ff, eval_ptr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]    run_cnt_ff, run_cnt_in;
   logic [CNT_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]    end_ff, end_in;
   logic [ADDR_W-1:0]   va_ff, va_in;
   status_type          status_ff, status_in;
   logic [CNT_W-1:0]    frames_used_ff, frames_used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [PHYS_W-1:0]   rsp_phys_ff, rsp_phys_in;
   logic [ADDR_W-1:0]   rsp_virt_ff, rsp_virt_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic [CNT_W-1:0]    top_frames;
   logic [CNT_W-1:0]    eval_next;
   logic [CNT_W:0]      clr_sum;
   logic [CNT_W-1:0]    clr_end;
   logic [PHYS_W-1:0]   phys_of_start;
   logic [ADDR_W-1:0]   va_calc;
   logic [CNT_W-1:0]    frames_dec;
   scan_ctx_type        scan_ctx;
   scan_res_type        scan_res;

   // Managed top of the map and helper values
   assign top_frames    = (cfg.present < CNT_W'(NUM_FRAMES)) ? cfg.present
                                                             : CNT_W'(NUM_FRAMES);
   assign eval_next     = eval_ptr_ff + CNT_W'(1);
   assign clr_sum       = {1'b0, eval_ptr_ff} +
                          {{(CNT_W + 1 - NPAGES_W){1'b0}}, ram_rd_data.len};
   assign clr_end       = (clr_sum > (CNT_W + 1)'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES)
                                                                : clr_sum[CNT_W-1:0];
   assign phys_of_start = {start_ff[IDX_W-1:0], {PAGE_SHIFT{1'b0}}};
   assign va_calc       = cfg.kernel_base + {{(ADDR_W - PHYS_W){1'b0}}, phys_of_start};
   assign frames_dec    = (frames_used_ff != '0) ? frames_used_ff - CNT_W'(1)
                                                 : frames_used_ff;

   // Shared compare unit
   always_comb begin
      scan_ctx.rec     = ram_rd_data;
      scan_ctx.vaddr   = vaddr_ff;
      scan_ctx.owner   = owner_ff;
      scan_ctx.npages  = (state_ff == ST_IDLE) ? req_npages : npages_ff;
      scan_ctx.run_cnt = run_cnt_ff;
      scan_ctx.base    = (state_ff == ST_IDLE) ? cfg.reserved : eval_next;
      scan_ctx.top     = top_frames;
   end

   cpfa_scan_unit u_scan (
      .ctx (scan_ctx),
      .res (scan_res)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      npages_in      = npages_ff;
      vaddr_in       = vaddr_ff;
      owner_in       = owner_ff;
      issue_ptr_in   = issue_ptr_ff;
      eval_ptr_in    = eval_ptr_ff;
      rd_vld_in      = 1'b0;
      run_cnt_in     = run_cnt_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      va_in          = va_ff;
      status_in      = status_ff;
      frames_used_in = frames_used_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_phys_in    = rsp_phys_ff;
      rsp_virt_in    = rsp_virt_ff;
      rsp_used_in    = rsp_used_ff;
      ram_wr         = '0;
      ram_rd_addr    = issue_ptr_ff[IDX_W-1:0];

      case (state_ff)
         // Zero the whole map once after reset
         ST_CLEAR: begin
            ram_wr.en    = 1'b1;
            ram_wr.addr  = issue_ptr_ff[IDX_W-1:0];
            issue_ptr_in = issue_ptr_ff + CNT_W'(1);
            if (issue_ptr_ff[IDX_W-1:0] == IDX_W'(NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take an item and pick the operation
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = op_type'(req_op);
               npages_in    = req_npages;
               vaddr_in     = req_vaddr;
               owner_in     = req_owner;
               run_cnt_in   = '0;
               start_in     = cfg.reserved;
               issue_ptr_in = cfg.reserved;
               status_in    = STATUS_OK;
               case (op_type'(req_op))
                  OP_ALLOC: begin
                     if (req_npages == '0 || !scan_res.fits) begin
                        status_in = STATUS_NO_RUN;
                        state_in  = ST_FIN;
                     end else begin
                        state_in = ST_ASCAN;
                     end
                  end
                  OP_FREE_ADDR: begin
                     if (cfg.reserved >= top_frames) begin
                        status_in = STATUS_NOT_FOUND;
                        state_in  = ST_FIN;
                     end else begin
                        state_in = ST_FSCAN;
                     end
                  end
                  OP_FREE_INDEX: begin
                     issue_ptr_in = {1'b0, req_page_index};
                     if ({1'b0, req_page_index} >= top_frames) begin
                        status_in = STATUS_MISMATCH;
                        state_in  = ST_FIN;
                     end else begin
                        state_in = ST_XREAD;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         // First-fit search, one record per cycle
         ST_ASCAN: begin
            issue_ptr_in = issue_ptr_ff + CNT_W'(1);
            eval_ptr_in  = issue_ptr_ff;
            rd_vld_in    = 1'b1;
            if (rd_vld_ff) begin
               if (ram_rd_data.used) begin
                  run_cnt_in = '0;
                  start_in   = eval_next;
                  if (!scan_res.fits) begin
                     status_in = STATUS_NO_RUN;
                     state_in  = ST_FIN;
                  end
               end else if (scan_res.run_done) begin
                  va_in        = (vaddr_ff != '0) ? vaddr_ff : va_calc;
                  issue_ptr_in = start_ff;
                  run_cnt_in   = '0;
                  state_in     = ST_AMARK;
               end else begin
                  run_cnt_in = run_cnt_ff + CNT_W'(1);
               end
            end
         end

         // Mark the run, one record per cycle
         ST_AMARK: begin
            ram_wr.en         = 1'b1;
            ram_wr.addr       = issue_ptr_ff[IDX_W-1:0];
            ram_wr.data.used  = 1'b1;
            ram_wr.data.first = run_cnt_ff == '0;
            ram_wr.data.len   = npages_ff;
            ram_wr.data.owner = owner_ff;
            ram_wr.data.vaddr = va_ff;
            frames_used_in    = frames_used_ff + CNT_W'(1);
            issue_ptr_in      = issue_ptr_ff + CNT_W'(1);
            run_cnt_in        = run_cnt_ff + CNT_W'(1);
            if (scan_res.run_done) begin
               state_in = ST_FIN;
            end
         end

         // Look for the first in-use record with this address and owner
         ST_FSCAN: begin
            issue_ptr_in = issue_ptr_ff + CNT_W'(1);
            eval_ptr_in  = issue_ptr_ff;
            rd_vld_in    = 1'b1;
            if (rd_vld_ff) begin
               if (scan_res.match) begin
                  rd_vld_in = 1'b0;
                  if (!ram_rd_data.first) begin
                     status_in = STATUS_MISMATCH;
                     state_in  = ST_FIN;
                  end else begin
                     end_in       = clr_end;
                     issue_ptr_in = eval_ptr_ff;
                     state_in     = ST_FCLEAR;
                  end
               end else if (eval_next == top_frames) begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_FIN;
               end
            end
         end

         // Read ahead and clear the run behind it
         ST_FCLEAR: begin
            if (issue_ptr_ff < end_ff) begin
               issue_ptr_in = issue_ptr_ff + CNT_W'(1);
               eval_ptr_in  = issue_ptr_ff;
               rd_vld_in    = 1'b1;
            end
            if (rd_vld_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = eval_ptr_ff[IDX_W-1:0];
               if (ram_rd_data.used) begin
                  frames_used_in = frames_dec;
               end
            end else if (issue_ptr_ff >= end_ff) begin
               status_in = STATUS_OK;
               state_in  = ST_FIN;
            end
         end

         ST_XREAD: begin
            state_in = ST_XCHECK;
         end

         // Check one record and clear it on a match
         ST_XCHECK: begin
            if (scan_res.match) begin
               ram_wr.en      = 1'b1;
               ram_wr.addr    = issue_ptr_ff[IDX_W-1:0];
               frames_used_in = frames_dec;
               status_in      = STATUS_OK;
            end else begin
               status_in = STATUS_MISMATCH;
            end
            state_in = ST_FIN;
         end

         // Hand the result to the output register once it is free
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (op_ff == OP_ALLOC && status_ff == STATUS_OK) begin
                  rsp_phys_in = phys_of_start;
                  rsp_virt_in = va_ff;
               end else begin
                  rsp_phys_in = '0;
                  rsp_virt_in = '0;
               end
               rsp_used_in = {frames_used_ff, {PAGE_SHIFT{1'b0}}};
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         issue_ptr_ff   <= '0;
         rd_vld_ff      <= 1'b0;
         frames_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_ptr_ff   <= issue_ptr_in;
         rd_vld_ff      <= rd_vld_in;
         frames_used_ff <= frames_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Operands and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      npages_ff     <= npages_in;
      vaddr_ff      <= vaddr_in;
      owner_ff      <= owner_in;
      eval_ptr_ff   <= eval_ptr_in;
      run_cnt_ff    <= run_cnt_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      va_ff         <= va_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_virt_ff   <= rsp_virt_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_virt_addr  = rsp_virt_ff;
   assign rsp_used_bytes = rsp_used_ff;

endmodule

`default_nettype wire

/* design/contiguous_page_frame_allocator.sv */
// Operation: usage goes straight to the result; free at index reads, checks and clears one record;
//   allocate scans one frame record per cycle from the reserved count to the first fitting run,
//   then marks npages records at one per cycle; free by address scans one record per
//   cycle to the match and clears the run at one record per cycle.
// Throughput: one item at a time, paced by the single read and write port of the frame map.
// Reset: synchronous; a clearing pass then zeroes all 1024 records, req_ready low.
`default_nettype none

module contiguous_page_frame_allocator
   import cpfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [NPAGES_W-1:0]   req_npages,
   input  logic [ADDR_W-1:0]     req_vaddr,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic [PIDX_W-1:0]     req_page_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PHYS_W-1:0]     rsp_phys_addr,
   output logic [ADDR_W-1:0]     rsp_virt_addr,
   output logic [USED_W-1:0]     rsp_used_bytes,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0]  reserved_ff;
   logic [CNT_W-1:0]  present_ff;
   logic [ADDR_W-1:0] kbase_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;
   cfg_type           cfg;
   ram_wr_type        ram_wr;
   logic [IDX_W-1:0]  ram_rd_addr;
   frame_rec_type     ram_rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= RESERVED_RST;
         present_ff  <= PRESENT_RST;
         kbase_ff    <= KBASE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_RESERVED: reserved_ff <= csr_pwdata[CNT_W-1:0];
            REG_PRESENT:  present_ff  <= csr_pwdata[CNT_W-1:0];
            REG_KBASE:    kbase_ff    <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_idx)
         REG_RESERVED: csr_prdata = {{(CSR_DATA_W - CNT_W){1'b0}}, reserved_ff};
         REG_PRESENT:  csr_prdata = {{(CSR_DATA_W - CNT_W){1'b0}}, present_ff};
         REG_KBASE:    csr_prdata = kbase_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.reserved    = reserved_ff;
      cfg.present     = present_ff;
      cfg.kernel_base = kbase_ff;
   end

   cpfa_frame_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cpfa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_npages     (req_npages),
      .req_vaddr      (req_vaddr),
      .req_owner      (req_owner),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_virt_addr  (rsp_virt_addr),
      .rsp_used_bytes (rsp_used_bytes),
      .ram_wr         (ram_wr),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

endmodule

`default_nettype wire

/* design/cpfa_checker.sv */
`default_nettype none

module cpfa_checker
   import cpfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [PHYS_W-1:0]     rsp_phys_addr,
   input  logic [ADDR_W-1:0]     rsp_virt_addr,
   input  logic [USED_W-1:0]     rsp_used_bytes
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Count items taken but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_phys_addr) && $stable(rsp_virt_addr) && $stable(rsp_used_bytes))
      else $error("result changed while stalled");

   // Map clearing keeps the input closed after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("item taken during map clearing");

   // Every result belongs to an item taken earlier
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an item");

   // Failed results carry no addresses; only the status is tested, not the operation
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_phys_addr == '0 && rsp_virt_addr == '0)
      else $error("address reported on failure");

   // Usage is whole frames within the map
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_bytes[PAGE_SHIFT-1:0] == '0 &&
      rsp_used_bytes <= USED_W'(NUM_FRAMES * FRAME_BYTES))
      else $error("used bytes out of range");

endmodule

bind contiguous_page_frame_allocator cpfa_checker u_checker (.*);

`default_nettype wire
